// ----- rtl/asp_pkg.sv -----
// Shared types, constants and register codes of the analytic shape pixel accumulator.
// Used by every module in rtl/; depends on nothing else.
package asp_pkg;

    localparam int GRID_SIZE_DEF = 256;

    localparam int IDX_W   = 8;            // pixel index width
    localparam int IDX_N   = 1 << IDX_W;
    localparam int XW      = 25;           // unsigned index-to-coordinate offset
    localparam int CRD_W   = 27;           // signed coordinate differences, Q.16
    localparam int PRD_W   = 45;           // coordinate times sin/cos
    localparam int SUM_W   = 46;
    localparam int TERM_W  = 41;           // one saturated quadratic term
    localparam int T_W     = 42;           // T, Q.16
    localparam int Q30_W   = 31;           // gaussian factor, Q.30
    localparam int ROOT_W  = 17;           // square root result, Q.16
    localparam int NTERMS  = 13;           // Taylor terms of exp(-z)
    localparam int SQ_STEPS = 17;          // one result bit per step
    localparam int REG_IDX_W = 3;
    localparam int CFG_DW  = 32;

    localparam logic [29:0]       LN2_Q30 = 30'd744261118;
    localparam logic [Q30_W-1:0]  ONE_Q30 = 31'h4000_0000;
    localparam logic [TERM_W-1:0] T_CAP   = 41'h100_0000_0000;

    typedef enum logic [2:0] {
        SHP_GAUSS   = 3'd0,
        SHP_PARAB   = 3'd1,
        SHP_ELLIPSE = 3'd2,
        SHP_PARAB1  = 3'd3,
        SHP_CONE    = 3'd4,
        SHP_RECT    = 3'd5
    } t_shape;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SHAPE  = 3'd0,
        REG_INTENS = 3'd1,
        REG_CX     = 3'd2,
        REG_CY     = 3'd3,
        REG_KA     = 3'd4,
        REG_KB     = 3'd5,
        REG_SIN    = 3'd6,
        REG_COS    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]         shape;
        logic signed [31:0] c0;
        logic signed [17:0] cx;
        logic signed [17:0] cy;
        logic [31:0]        ka;
        logic [31:0]        kb;
        logic signed [17:0] sn;
        logic signed [17:0] cs;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0]  pix;
        logic                hit;
        logic [T_W-1:0]      t;
        logic [Q30_W-1:0]    gfac;
        logic                in_range;
        logic [ROOT_W-1:0]   root;
    } t_item;

endpackage

// ----- rtl/asp_geom.sv -----
// Geometry pipeline: index to coordinate, rotation, rectangle test and T = A*u^2 + B*v^2.
// Depends on asp_pkg.
module asp_geom import asp_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [IDX_W-1:0]    i_col,
    input  logic [IDX_W-1:0]    i_row,
    input  logic signed [31:0]  i_pix,
    input  t_cfg                i_cfg,
    output logic                o_vld,
    output t_item               o_item
);

    localparam int NST = 8;

    logic [XW-1:0] w_xtab [IDX_N];
    for (genvar c = 0; c < IDX_N; c++) begin : g_xtab
        assign w_xtab[c] = XW'((c * 131072) / GRID_SIZE);
    end

    logic signed [CRD_W-1:0] w_x, w_y, w_cx, w_cy, w_ex, w_ey;
    logic                    w_rect;

    assign w_rect = (i_cfg.shape == SHP_RECT);
    assign w_cx   = CRD_W'(i_cfg.cx);
    assign w_cy   = CRD_W'(i_cfg.cy);
    assign w_x    = $signed({2'b00, w_xtab[i_col]}) - $signed(CRD_W'(65536));
    assign w_y    = $signed({2'b00, w_xtab[i_row]}) - $signed(CRD_W'(65536));
    // rectangle takes the centre offset twice
    assign w_ex   = w_x - w_cx - (w_rect ? w_cx : '0);
    assign w_ey   = w_y - w_cy - (w_rect ? w_cy : '0);

    logic               r_vld [NST];
    logic signed [31:0] r_pix [NST];
    logic               r_hit [5];

    logic signed [CRD_W-1:0] r1_ex, r1_ey;
    logic signed [PRD_W-1:0] r2_pa, r2_pb, r2_pc, r2_pd;
    logic signed [SUM_W-1:0] r3_hx, r3_hy, r3_su, r3_sv;
    logic [29:0]             r4_au, r4_av;
    logic [59:0]             r5_su2, r5_sv2;
    logic [61:0]             r6_pah, r6_pal, r6_pbh, r6_pbl;
    logic [TERM_W-1:0]       r7_ta, r7_tb;
    logic [T_W-1:0]          r8_t;

    logic signed [29:0]      w_u, w_v;
    logic [29:0]             w_au, w_av;
    logic [SUM_W-1:0]        w_ahx, w_ahy;
    logic                    w_hit;
    logic [91:0]             w_tota, w_totb;
    logic [TERM_W-1:0]       w_ta, w_tb;

    assign w_u   = r3_su[SUM_W-1:16];
    assign w_v   = r3_sv[SUM_W-1:16];
    assign w_au  = w_u[29] ? (~w_u + 30'd1) : w_u;
    assign w_av  = w_v[29] ? (~w_v + 30'd1) : w_v;
    assign w_ahx = r3_hx[SUM_W-1] ? (~r3_hx + 46'd1) : r3_hx;
    assign w_ahy = r3_hy[SUM_W-1] ? (~r3_hy + 46'd1) : r3_hy;
    assign w_hit = ({2'b00, w_ahx} <= {i_cfg.ka, 16'h0000})
                && ({2'b00, w_ahy} <= {i_cfg.kb, 16'h0000});

    // a product of 2^64 or more caps the term at 2^40
    assign w_tota = {r6_pah, 30'd0} + 92'(r6_pal);
    assign w_totb = {r6_pbh, 30'd0} + 92'(r6_pbl);
    assign w_ta   = (|w_tota[91:64]) ? T_CAP : TERM_W'(w_tota[63:32]);
    assign w_tb   = (|w_totb[91:64]) ? T_CAP : TERM_W'(w_totb[63:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < NST; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix[0] <= i_pix;
            for (int s = 1; s < NST; s++) r_pix[s] <= r_pix[s-1];
            r1_ex  <= w_ex;
            r1_ey  <= w_ey;
            r2_pa  <= r1_ex * i_cfg.cs;
            r2_pb  <= r1_ey * i_cfg.sn;
            r2_pc  <= r1_ey * i_cfg.cs;
            r2_pd  <= r1_ex * i_cfg.sn;
            r3_hx  <= SUM_W'(r2_pd) + SUM_W'(r2_pc);
            r3_hy  <= SUM_W'(r2_pb) - SUM_W'(r2_pa);
            r3_su  <= SUM_W'(r2_pa) + SUM_W'(r2_pb);
            r3_sv  <= SUM_W'(r2_pc) - SUM_W'(r2_pd);
            r4_au  <= w_au;
            r4_av  <= w_av;
            r_hit[0] <= w_hit;
            for (int s = 1; s < 5; s++) r_hit[s] <= r_hit[s-1];
            r5_su2 <= r4_au * r4_au;
            r5_sv2 <= r4_av * r4_av;
            r6_pah <= i_cfg.ka * r5_su2[59:30];
            r6_pal <= i_cfg.ka * r5_su2[29:0];
            r6_pbh <= i_cfg.kb * r5_sv2[59:30];
            r6_pbl <= i_cfg.kb * r5_sv2[29:0];
            r7_ta  <= w_ta;
            r7_tb  <= w_tb;
            r8_t   <= T_W'(r7_ta) + T_W'(r7_tb);
        end
    end

    always_comb begin
        o_item        = '0;
        o_item.pix    = r_pix[NST-1];
        o_item.hit    = r_hit[4];
        o_item.t      = r8_t;
    end
    assign o_vld = r_vld[NST-1];

endmodule

// ----- rtl/asp_gauss.sv -----
// Gaussian factor 2^(-4T) in Q.30: alternating Taylor series of exp(-z), three stages a term.
// Depends on asp_pkg.
module asp_gauss import asp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    typedef struct packed {
        t_item      item;
        logic       zero;
        logic [4:0] sh;
    } t_gctl;

    logic [43:0] w_e;
    logic [45:0] w_zp;

    assign w_e  = {i_item.t, 2'b00};
    assign w_zp = w_e[15:0] * LN2_Q30;

    logic        r0_vld;
    t_gctl       r0_ctl;
    logic [29:0] r0_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_vld <= 1'b0;
        else if (i_en) r0_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_ctl <= {i_item, (w_e[43:16] > 28'd30), w_e[20:16]};
            r0_z   <= w_zp[45:16];
        end
    end

    logic               rA_vld [NTERMS];
    logic [29:0]        rA_m   [NTERMS];
    logic signed [32:0] rA_sum [NTERMS];
    logic [29:0]        rA_z   [NTERMS];
    t_gctl              rA_ctl [NTERMS];
    logic               rB_vld [NTERMS];
    logic [29:0]        rB_q0  [NTERMS];
    logic [29:0]        rB_m   [NTERMS];
    logic signed [32:0] rB_sum [NTERMS];
    logic [29:0]        rB_z   [NTERMS];
    t_gctl              rB_ctl [NTERMS];
    logic               rC_vld [NTERMS];
    logic [Q30_W-1:0]   rC_term[NTERMS];
    logic signed [32:0] rC_sum [NTERMS];
    logic [29:0]        rC_z   [NTERMS];
    t_gctl              rC_ctl [NTERMS];

    for (genvar j = 0; j < NTERMS; j++) begin : g_term
        localparam int NV = j + 1;
        localparam logic [30:0] RECIP = 31'((64'd1 << 30) / NV);

        logic               vi;
        logic [Q30_W-1:0]   ti;
        logic signed [32:0] si;
        logic [29:0]        zi;
        t_gctl              ci;
        logic [60:0]        pa, pb;
        logic [29:0]        rr, q;
        logic signed [32:0] sn;

        if (j == 0) begin : g_first
            assign vi = r0_vld;
            assign ti = ONE_Q30;
            assign si = $signed({2'b00, ONE_Q30});
            assign zi = r0_z;
            assign ci = r0_ctl;
        end else begin : g_next
            assign vi = rC_vld[j-1];
            assign ti = rC_term[j-1];
            assign si = rC_sum[j-1];
            assign zi = rC_z[j-1];
            assign ci = rC_ctl[j-1];
        end

        assign pa = ti * zi;
        assign pb = rA_m[j] * RECIP;
        // reciprocal quotient is exact or one low; fix with the remainder
        assign rr = rB_m[j] - 30'(rB_q0[j] * 30'(NV));
        assign q  = (rr >= 30'(NV)) ? rB_q0[j] + 30'd1 : rB_q0[j];

        if ((j % 2) == 0) begin : g_sub
            assign sn = rB_sum[j] - $signed({3'b000, q});
        end else begin : g_add
            assign sn = rB_sum[j] + $signed({3'b000, q});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rA_vld[j] <= 1'b0;
                rB_vld[j] <= 1'b0;
                rC_vld[j] <= 1'b0;
            end else if (i_en) begin
                rA_vld[j] <= vi;
                rB_vld[j] <= rA_vld[j];
                rC_vld[j] <= rB_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                rA_m[j]    <= pa[59:30];
                rA_sum[j]  <= si;
                rA_z[j]    <= zi;
                rA_ctl[j]  <= ci;
                rB_q0[j]   <= pb[59:30];
                rB_m[j]    <= rA_m[j];
                rB_sum[j]  <= rA_sum[j];
                rB_z[j]    <= rA_z[j];
                rB_ctl[j]  <= rA_ctl[j];
                rC_term[j] <= {1'b0, q};
                rC_sum[j]  <= sn;
                rC_z[j]    <= rB_z[j];
                rC_ctl[j]  <= rB_ctl[j];
            end
        end
    end

    logic               rF_vld;
    t_item              rF_item;
    logic signed [32:0] w_sf;
    logic [32:0]        w_pos, w_g;
    t_gctl              w_lc;
    t_item              w_fin;

    assign w_lc  = rC_ctl[NTERMS-1];
    assign w_sf  = rC_sum[NTERMS-1];
    assign w_pos = w_sf[32] ? 33'd0 : w_sf;
    assign w_g   = w_lc.zero ? 33'd0 : (w_pos >> w_lc.sh);

    always_comb begin
        w_fin      = w_lc.item;
        w_fin.gfac = w_g[Q30_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rF_vld <= 1'b0;
        else if (i_en) rF_vld <= rC_vld[NTERMS-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rF_item <= w_fin;
        end
    end

    assign o_vld  = rF_vld;
    assign o_item = rF_item;

endmodule

// ----- rtl/asp_sqrt.sv -----
// Pipelined integer square root for the parabola and cone shapes, one result bit a stage.
// Depends on asp_pkg.
module asp_sqrt import asp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic [43:0] w_tt;
    logic [16:0] w_t17;
    logic [33:0] w_arg;
    t_item       w_item0;

    assign w_tt  = (i_cfg.shape == SHP_PARAB1) ? {i_item.t, 2'b00} : {2'b00, i_item.t};
    assign w_t17 = w_tt[16:0];
    assign w_arg = (i_cfg.shape == SHP_CONE) ? {1'b0, w_t17, 16'h0000}
                                             : {1'b0, 17'd65536 - w_t17, 16'h0000};

    always_comb begin
        w_item0          = i_item;
        w_item0.in_range = (w_tt <= 44'd65536);
    end

    logic        r0_vld;
    t_item       r0_item;
    logic [33:0] r0_arg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_vld <= 1'b0;
        else if (i_en) r0_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_item <= w_item0;
            r0_arg  <= w_arg;
        end
    end

    logic              r_vld  [SQ_STEPS];
    t_item             r_item [SQ_STEPS];
    logic [33:0]       r_arg  [SQ_STEPS];
    logic [17:0]       r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] r_root [SQ_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
        logic              vi;
        t_item             ii;
        logic [33:0]       ai;
        logic [17:0]       mi;
        logic [ROOT_W-1:0] oi;
        logic [19:0]       cur, trial;
        logic              ge;

        if (s == 0) begin : g_first
            assign vi = r0_vld;
            assign ii = r0_item;
            assign ai = r0_arg;
            assign mi = '0;
            assign oi = '0;
        end else begin : g_next
            assign vi = r_vld[s-1];
            assign ii = r_item[s-1];
            assign ai = r_arg[s-1];
            assign mi = r_rem[s-1];
            assign oi = r_root[s-1];
        end

        assign cur   = {mi, ai[33:32]};
        assign trial = {1'b0, oi, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[s] <= 1'b0;
            else if (i_en) r_vld[s] <= vi;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[s] <= ii;
                r_arg[s]  <= {ai[31:0], 2'b00};
                r_rem[s]  <= ge ? 18'(cur - trial) : 18'(cur);
                r_root[s] <= {oi[ROOT_W-2:0], ge};
            end
        end
    end

    always_comb begin
        o_item      = r_item[SQ_STEPS-1];
        o_item.root = r_root[SQ_STEPS-1];
    end
    assign o_vld = r_vld[SQ_STEPS-1];

endmodule

// ----- rtl/asp_out.sv -----
// Shape select, intensity multiply, saturating add and the two-entry output queue.
// Depends on asp_pkg; drives the pipeline advance enable.
module asp_out import asp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_vld,
    input  t_item              i_item,
    output logic               o_en,
    output logic               o_vld,
    input  logic               i_rdy,
    output logic signed [31:0] o_pix
);

    logic [Q30_W-1:0] w_g;
    logic             w_sh30;

    always_comb begin
        w_g    = '0;
        w_sh30 = 1'b0;
        case (i_cfg.shape)
            SHP_GAUSS: begin
                w_g    = i_item.gfac;
                w_sh30 = 1'b1;
            end
            SHP_PARAB, SHP_PARAB1: begin
                if (i_item.in_range) w_g = Q30_W'(i_item.root);
            end
            SHP_CONE: begin
                if (i_item.in_range) w_g = Q30_W'(17'd65536 - i_item.root);
            end
            SHP_ELLIPSE: begin
                if (i_item.in_range) w_g = Q30_W'(65536);
            end
            SHP_RECT: begin
                if (i_item.hit) w_g = Q30_W'(65536);
            end
            default: w_g = '0;
        endcase
    end

    logic                r0_vld, r1_vld;
    logic [Q30_W-1:0]    r0_g;
    logic                r0_sh30, r1_sh30;
    logic signed [31:0]  r0_pix, r1_pix;
    logic signed [63:0]  r1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else if (o_en) begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r0_g    <= w_g;
            r0_sh30 <= w_sh30;
            r0_pix  <= i_item.pix;
            r1_prod <= i_cfg.c0 * $signed({1'b0, r0_g});
            r1_sh30 <= r0_sh30;
            r1_pix  <= r0_pix;
        end
    end

    logic signed [63:0] w_shr;
    logic signed [34:0] w_res;
    logic signed [31:0] w_sat;

    // the shifted product fits 34 signed bits, so bit 34 already carries its sign
    assign w_shr = r1_sh30 ? (r1_prod >>> 30) : (r1_prod >>> 16);
    assign w_res = 35'(r1_pix) + w_shr[34:0];
    always_comb begin
        if (w_res[34:31] == 4'b0000 || w_res[34:31] == 4'b1111) w_sat = w_res[31:0];
        else if (w_res[34]) w_sat = 32'sh8000_0000;
        else w_sat = 32'sh7fff_ffff;
    end

    // two-entry queue: the pipeline advances whenever a slot is free
    logic [1:0]         r_cnt;
    logic               r_wp, r_rp;
    logic signed [31:0] r_mem [2];
    logic               w_push, w_pop;

    assign o_en   = (r_cnt != 2'd2);
    assign w_push = o_en && r1_vld;
    assign w_pop  = (r_cnt != 2'd0) && i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_sat;
    end

    assign o_vld = (r_cnt != 2'd0);
    assign o_pix = r_mem[r_rp];

endmodule

// ----- rtl/analytic_shape_pixel_accumulator.sv -----
// Top level: configuration registers and the four pipeline sections.
// Depends on asp_pkg, asp_geom, asp_gauss, asp_sqrt and asp_out.
//
// Adds one rotated analytic object (gaussian, parabola, ellipse, parabola1, cone or
// rectangle) to a stream of pixels. Each request carries a column index, a row index and
// the current pixel value in signed Q16.16; the block returns that value plus the
// object's contribution, saturated to 32 bits, in request order. The datapath is a
// single pipeline of about 70 register stages: coordinate and rotation (8 stages), the
// 13-term exp series of the gaussian at three stages a term (41 stages), a one-bit-per-
// stage square root (18 stages) and the intensity multiply with saturating add (3 stages
// including the output queue). It takes one request every cycle while the queue has room.
// A two-entry output queue holds finished results, so the input keeps flowing while one
// result waits, and the whole pipeline holds only when both entries are full. Program
// the shape registers through the write port only while no request is in flight;
// register writes take effect at once and have no read-back.
module analytic_shape_pixel_accumulator import asp_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IDX_W-1:0]      i_col_index,
    input  logic [IDX_W-1:0]      i_row_index,
    input  logic signed [31:0]    i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_pixel_out,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DW-1:0]     i_cfg_data
);

    t_cfg r_cfg;

    // hold the object description; writes land on the addressed field only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape <= SHP_ELLIPSE;
            r_cfg.c0    <= '0;
            r_cfg.cx    <= '0;
            r_cfg.cy    <= '0;
            r_cfg.ka    <= 32'd65536;
            r_cfg.kb    <= 32'd65536;
            r_cfg.sn    <= '0;
            r_cfg.cs    <= 18'sd65536;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SHAPE:  r_cfg.shape <= i_cfg_data[2:0];
                REG_INTENS: r_cfg.c0    <= i_cfg_data;
                REG_CX:     r_cfg.cx    <= i_cfg_data[17:0];
                REG_CY:     r_cfg.cy    <= i_cfg_data[17:0];
                REG_KA:     r_cfg.ka    <= i_cfg_data;
                REG_KB:     r_cfg.kb    <= i_cfg_data;
                REG_SIN:    r_cfg.sn    <= i_cfg_data[17:0];
                REG_COS:    r_cfg.cs    <= i_cfg_data[17:0];
                default:    r_cfg.shape <= r_cfg.shape;
            endcase
        end
    end

    logic  w_en;
    logic  w_geo_vld, w_gau_vld, w_sq_vld;
    t_item w_geo_item, w_gau_item, w_sq_item;

    // every stage advances together; the output queue decides when
    assign o_in_ready = w_en;

    asp_geom #(
        .GRID_SIZE (GRID_SIZE)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_col   (i_col_index),
        .i_row   (i_row_index),
        .i_pix   (i_pixel_in),
        .i_cfg   (r_cfg),
        .o_vld   (w_geo_vld),
        .o_item  (w_geo_item)
    );

    asp_gauss u_gauss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_geo_vld),
        .i_item  (w_geo_item),
        .o_vld   (w_gau_vld),
        .o_item  (w_gau_item)
    );

    asp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_vld   (w_gau_vld),
        .i_item  (w_gau_item),
        .o_vld   (w_sq_vld),
        .o_item  (w_sq_item)
    );

    asp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (w_sq_vld),
        .i_item  (w_sq_item),
        .o_en    (w_en),
        .o_vld   (o_out_valid),
        .i_rdy   (i_out_ready),
        .o_pix   (o_pixel_out)
    );

endmodule

// ----- test/analytic_shape_pixel_accumulator_tb.sv -----
// Self-checking testbench of analytic_shape_pixel_accumulator: random and directed pixels,
// shape settings and handshake gaps, checked against a built-in pixel predictor.
// Depends on asp_pkg and the RTL in rtl/.
`timescale 1ns / 100ps

module analytic_shape_pixel_accumulator_tb;
    import asp_pkg::*;

    localparam int GRID      = 256;
    localparam int SETTLE    = 100;     // pipeline depth is about 70 stages
    localparam int IDLE_MAX  = 2000;    // cycles without any accepted request or result before giving up
    localparam longint unsigned QUAD_CAP = 64'd1 << 40;
    localparam longint unsigned LN2_FRAC = 64'd744261118;

    typedef struct {
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [31:0] pix;
    } t_pixel_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [IDX_W-1:0]      i_col_index = '0;
    logic [IDX_W-1:0]      i_row_index = '0;
    logic signed [31:0]    i_pixel_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [31:0]    o_pixel_out;
    logic                  i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DW-1:0]     i_cfg_data = '0;

    t_pixel_req         pending_reqs[$];
    logic signed [31:0] expected_pixels[$];
    t_cfg               shape_cfg;
    int                 fail_count = 0;
    int                 quiet_cycles = 0;
    logic               req_taken = 1'b0;
    int                 in_gap = 0;
    int                 out_gap = 0;
    bit                 no_idle = 1'b0;

    always #10 i_clk = ~i_clk;

    analytic_shape_pixel_accumulator #(.GRID_SIZE(GRID)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_col_index(i_col_index), .i_row_index(i_row_index), .i_pixel_in(i_pixel_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_pixel_out(o_pixel_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Floor square root, bit by bit.
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r, bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w >>= 2;
        while (bit_w != 0) begin
            if (n >= r + bit_w) begin
                n -= r + bit_w;
                r = (r >> 1) + bit_w;
            end else begin
                r >>= 1;
            end
            bit_w >>= 2;
        end
        return r;
    endfunction

    // coef * w^2 / 2^32, clamped at 2^40; a 64-bit overflow also clamps.
    function automatic longint unsigned quad_term(logic [31:0] coef, longint w);
        longint unsigned aw, sq;
        logic [127:0]    p;
        aw = (w < 0) ? -w : w;
        sq = aw * aw;
        p = {96'd0, coef} * {64'd0, sq};
        if (p[127:64] != 0) return QUAD_CAP;
        p = p >> 32;
        return (p > QUAD_CAP) ? QUAD_CAP : p[63:0];
    endfunction

    // 2^(-e) for e in Q.16, returned in Q.30, via a 13-term series of exp(-z).
    function automatic longint gauss_factor(longint unsigned e);
        longint unsigned k, z;
        longint          term, sum;
        k = e >> 16;
        z = ((e & 64'hFFFF) * LN2_FRAC) >> 16;
        if (k > 30) return 0;
        term = 64'd1 << 30;
        sum = term;
        for (int n = 1; n <= NTERMS; n++) begin
            term = longint'(((longint'(term) * z) >> 30) / n);
            if (n % 2 == 1) sum -= term;
            else sum += term;
        end
        if (sum < 0) sum = 0;
        return sum >> k;
    endfunction

    // Expected pixel_out for one request under the current shape settings.
    function automatic logic signed [31:0] accumulate_pixel(t_cfg c, t_pixel_req rq);
        longint          x, y, dx, dy, cx, cy, sn, cs, c0, u, v, hx, hy, add, res;
        longint unsigned t;
        cx = c.cx;
        cy = c.cy;
        sn = c.sn;
        cs = c.cs;
        c0 = c.c0;
        x = -65536 + (longint'(rq.col) * 131072) / GRID;
        y = -65536 + (longint'(rq.row) * 131072) / GRID;
        dx = x - cx;
        dy = y - cy;
        add = 0;
        if (c.shape == SHP_RECT) begin
            // centre offset counts twice for the rectangle
            hx = (dx - cx) * sn + (dy - cy) * cs;
            hy = (dy - cy) * sn - (dx - cx) * cs;
            if (hx < 0) hx = -hx;
            if (hy < 0) hy = -hy;
            if (hx <= (longint'(c.ka) << 16) && hy <= (longint'(c.kb) << 16)) add = c0;
        end else if (c.shape <= SHP_CONE) begin
            u = (dx * cs + dy * sn) >>> 16;
            v = (dy * cs - dx * sn) >>> 16;
            t = quad_term(c.ka, u) + quad_term(c.kb, v);
            if (c.shape == SHP_GAUSS) begin
                add = (c0 * gauss_factor(t * 4)) >>> 30;
            end else begin
                if (c.shape == SHP_PARAB1) t = t * 4;
                if (t <= 65536) begin
                    if (c.shape == SHP_ELLIPSE) add = c0;
                    else if (c.shape == SHP_CONE)
                        add = (c0 * (65536 - longint'(floor_root(t << 16)))) >>> 16;
                    else
                        add = (c0 * longint'(floor_root((65536 - t) << 16))) >>> 16;
                end
            end
        end
        res = longint'(rq.pix) + add;
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    // Driver: present the next request at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        req_taken <= 1'b0;
        if (i_in_valid && !req_taken) begin
            // hold
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            i_in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && i_rst_n) begin
            t_pixel_req rq;
            rq = pending_reqs.pop_front();
            i_col_index <= rq.col;
            i_row_index <= rq.row;
            i_pixel_in <= rq.pix;
            i_in_valid <= 1'b1;
            in_gap <= draw_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_gap <= draw_gap();
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                t_pixel_req rq;
                rq.col = i_col_index;
                rq.row = i_row_index;
                rq.pix = i_pixel_in;
                expected_pixels.push_back(accumulate_pixel(shape_cfg, rq));
                req_taken <= 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out: no result expected, actual %0d", o_pixel_out);
                    fail_count++;
                end else begin
                    logic signed [31:0] want;
                    want = expected_pixels.pop_front();
                    if (want !== o_pixel_out) begin
                        $error("pixel_out: expected %0d, actual %0d", want, o_pixel_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_pixel(logic [7:0] col, logic [7:0] row, logic signed [31:0] pix);
        t_pixel_req rq;
        rq.col = col;
        rq.row = row;
        rq.pix = pix;
        pending_reqs.push_back(rq);
    endtask

    // Block until every request has been returned, then let the pipeline drain.
    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && !i_in_valid && expected_pixels.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(t_cfg c);
        logic [31:0] vals[8];
        vals[REG_SHAPE]  = {29'd0, c.shape};
        vals[REG_INTENS] = c.c0;
        vals[REG_CX]     = {{14{c.cx[17]}}, c.cx};
        vals[REG_CY]     = {{14{c.cy[17]}}, c.cy};
        vals[REG_KA]     = c.ka;
        vals[REG_KB]     = c.kb;
        vals[REG_SIN]    = {{14{c.sn[17]}}, c.sn};
        vals[REG_COS]    = {{14{c.cs[17]}}, c.cs};
        for (int i = 0; i < 8; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_reg_idx'(i);
            i_cfg_data <= vals[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shape_cfg = c;
    endtask

    task automatic random_cfg(output t_cfg c);
        real th;
        c.shape = 3'($urandom_range(SHP_GAUSS, SHP_RECT));
        c.c0 = 32'(($urandom_range(0, 3) == 0) ? $urandom()
               : $signed($urandom_range(0, 1 << 22)) - (1 << 21));
        c.cx = 18'(($urandom_range(0, 3) == 0) ? $urandom()
               : $urandom_range(0, 65535) - 32768);
        c.cy = 18'(($urandom_range(0, 3) == 0) ? $urandom()
               : $urandom_range(0, 65535) - 32768);
        if (c.shape == SHP_RECT) begin
            c.ka = $urandom_range(0, 1 << 17);
            c.kb = $urandom_range(0, 1 << 17);
        end else begin
            c.ka = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1 << 15, 1 << 22);
            c.kb = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1 << 15, 1 << 22);
        end
        if ($urandom_range(0, 4) == 0) begin
            // unnormalized rotation
            c.sn = 18'($urandom_range(0, 131072) - 65536);
            c.cs = 18'($urandom_range(0, 131072) - 65536);
        end else begin
            th = $urandom_range(0, 6283) / 1000.0;
            c.sn = 18'($rtoi(65536.0 * $sin(th)));
            c.cs = 18'($rtoi(65536.0 * $cos(th)));
        end
    endtask

    initial begin
        t_cfg c;
        // reset values of the register file
        shape_cfg.shape = SHP_ELLIPSE;
        shape_cfg.c0 = 0;
        shape_cfg.cx = 0;
        shape_cfg.cy = 0;
        shape_cfg.ka = 65536;
        shape_cfg.kb = 65536;
        shape_cfg.sn = 0;
        shape_cfg.cs = 65536;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, then each shape with extreme pixels and settings.
        queue_pixel(0, 0, 32'sh7FFF_FFFF);
        queue_pixel(255, 255, 32'sh8000_0000);
        queue_pixel(128, 128, 0);
        wait_drained();
        for (int s = SHP_GAUSS; s <= SHP_RECT; s++) begin
            c.shape = t_shape'(s);
            c.c0 = (s % 2 == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            c.cx = (s == SHP_CONE) ? 18'sh1FFFF : 0;
            c.cy = (s == SHP_CONE) ? 18'sh20000 : 0;
            c.ka = (s == SHP_RECT) ? 32'd32768 : ((s == SHP_PARAB) ? 32'hFFFF_FFFF : 32'd65536);
            c.kb = (s == SHP_RECT) ? 32'd16384 : ((s == SHP_PARAB) ? 32'd0 : 32'd262144);
            c.sn = (s == SHP_PARAB1) ? 18'sh10000 : ((s == SHP_RECT) ? -18'sh10000 : 0);
            c.cs = (s == SHP_PARAB1) ? 0 : ((s == SHP_RECT) ? -18'sh10000 : 18'sh10000);
            write_regs(c);
            queue_pixel(128, 128, 32'sh7FFF_0000);
            queue_pixel(128, 128, 32'sh8000_0000);
            queue_pixel(0, 255, 0);
            queue_pixel(255, 0, 1);
            queue_pixel(140, 120, -1);
            wait_drained();
        end

        // Random phases under random settings.
        for (int ph = 0; ph < 19; ph++) begin
            random_cfg(c);
            no_idle = (ph % 5 == 2);
            write_regs(c);
            for (int i = 0; i < 100; i++) begin
                logic signed [31:0] pix;
                pix = ($urandom_range(0, 3) == 0) ? $urandom()
                      : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
                queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), pix);
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
